[hdl/rgb_hsv_color_converter_unit_assert.svh]
// assertion macros for the color converter checker
`ifndef RGB_HSV_COLOR_CONVERTER_UNIT_ASSERT_SVH
`define RGB_HSV_COLOR_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rhc_pkg.sv]
`timescale 1ns / 1ps
package rhc_pkg;

	localparam logic MODE_RGB2HSV = 1'b0;
	localparam logic MODE_HSV2RGB = 1'b1;

	// hue scale: 256 steps per sextant
	localparam logic [10:0] HUE_CLAMP      = 11'd1536;
	localparam logic [11:0] HUE_SPAN       = 12'd1536;
	localparam logic [11:0] HUE_RED_BASE   = 12'd1536;
	localparam logic [11:0] HUE_GREEN_BASE = 12'd512;
	localparam logic [11:0] HUE_BLUE_BASE  = 12'd1024;
	localparam logic [8:0]  TRI_PEAK       = 9'd256;

	localparam int LATENCY = 5;

	typedef struct packed {
		logic        mode;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [10:0] hue_in;
		logic [7:0]  sat_in;
		logic [7:0]  val_in;
	} request_t;

	typedef struct packed {
		logic [10:0] hue_out;
		logic [7:0]  sat_out;
		logic [7:0]  val_out;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
	} result_t;

endpackage

[hdl/rgb_hsv_color_converter_unit.sv]
`timescale 1ns / 1ps
// Integer RGB/HSV color converter, fully pipelined: one item is taken in every clock
// cycle (busy is tied low). Its result shows on result, with done high for one cycle,
// once it has passed the front, divider and output stage registers. The receiver
// cannot stall, so each result must be captured in the cycle done is high. The depth
// comes from the two nine-step restoring dividers (hue and saturation), run three steps
// per stage over three stages, with one stage in front for max/min and the v*s product
// and one output stage for the hue offset, the saturation clamp and the channel placement.
module rgb_hsv_color_converter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rhc_pkg::request_t request,
	output logic              done,
	output rhc_pkg::result_t  result
);
	import rhc_pkg::*;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} hue_sel_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] v;
		logic [7:0] c;
		logic [7:0] x;
		logic [2:0] piece;
		logic [8:0] w;
		hue_sel_t   sel;
		logic       neg;
		logic [7:0] hrem;
		logic [8:0] hq;
		logic [7:0] srem;
		logic [8:0] sq;
	} pipe_t;

	// three restoring steps on both dividers: hue |num|*256/c, sat c*256/v
	function automatic pipe_t div_steps(input pipe_t p, input logic first);
		pipe_t      r;
		logic [8:0] t;
		logic [8:0] u;
		r = p;
		for (int i = 0; i < 3; i++) begin
			t = (first && (i == 0)) ? {1'b0, r.hrem} : {r.hrem, 1'b0};
			if (t >= {1'b0, r.c}) begin
				t = t - {1'b0, r.c};
				r.hq = {r.hq[7:0], 1'b1};
			end else begin
				r.hq = {r.hq[7:0], 1'b0};
			end
			r.hrem = t[7:0];
			u = (first && (i == 0)) ? {1'b0, r.srem} : {r.srem, 1'b0};
			if (u >= {1'b0, r.v}) begin
				u = u - {1'b0, r.v};
				r.sq = {r.sq[7:0], 1'b1};
			end else begin
				r.sq = {r.sq[7:0], 1'b0};
			end
			r.srem = u[7:0];
		end
		return r;
	endfunction

	logic    accept;
	logic    valid_s1, valid_s2, valid_s3, valid_s4;
	pipe_t   pipe_s1, pipe_s2, pipe_s3, pipe_s4;
	pipe_t   s1_d, s2_d, s3_d, s4_d;
	result_t result_d;
	result_t result_q;
	logic    done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// front stage: max/min, chroma, hue numerator, or v*s and hue triangle
	always_comb begin
		logic [7:0]  mx;
		logic [7:0]  mn;
		logic [8:0]  diff;
		logic [8:0]  mag;
		logic [15:0] vs;
		logic [10:0] hc;
		mx = (request.red_in > request.green_in) ? request.red_in : request.green_in;
		mn = (request.red_in < request.green_in) ? request.red_in : request.green_in;
		if (request.blue_in > mx) begin
			mx = request.blue_in;
		end
		if (request.blue_in < mn) begin
			mn = request.blue_in;
		end
		s1_d = '0;
		s1_d.mode = request.mode;
		// ties go red over green over blue
		if (mx == request.red_in) begin
			s1_d.sel = SEL_RED;
			diff = {1'b0, request.green_in} - {1'b0, request.blue_in};
		end else if (mx == request.green_in) begin
			s1_d.sel = SEL_GREEN;
			diff = {1'b0, request.blue_in} - {1'b0, request.red_in};
		end else begin
			s1_d.sel = SEL_BLUE;
			diff = {1'b0, request.red_in} - {1'b0, request.green_in};
		end
		s1_d.neg  = diff[8];
		mag       = diff[8] ? (9'd0 - diff) : diff;
		s1_d.hrem = mag[7:0];
		vs = request.val_in * request.sat_in;
		hc = (request.hue_in >= HUE_CLAMP) ? HUE_CLAMP : request.hue_in;
		s1_d.piece = hc[10:8];
		// 256 - |hue % 512 - 256|
		s1_d.w = hc[8] ? (TRI_PEAK - {1'b0, hc[7:0]}) : {1'b0, hc[7:0]};
		if (request.mode == MODE_HSV2RGB) begin
			s1_d.v = request.val_in;
			s1_d.c = vs[15:8];
		end else begin
			s1_d.v = mx;
			s1_d.c = mx - mn;
		end
		s1_d.srem = s1_d.c;
	end

	always_comb begin
		logic [16:0] xp;
		s2_d = div_steps(pipe_s1, 1'b1);
		xp   = pipe_s1.c * pipe_s1.w;
		s2_d.x = xp[15:8];
	end

	assign s3_d = div_steps(pipe_s2, 1'b0);
	assign s4_d = div_steps(pipe_s3, 1'b0);

	// output stage
	always_comb begin
		logic [11:0] base;
		logic [11:0] hs;
		logic [7:0]  m;
		logic [7:0]  rc, gc, bc;
		unique case (pipe_s4.sel)
			SEL_RED:   base = HUE_RED_BASE;
			SEL_GREEN: base = HUE_GREEN_BASE;
			SEL_BLUE:  base = HUE_BLUE_BASE;
			default:   base = HUE_RED_BASE;
		endcase
		hs = pipe_s4.neg ? (base - {3'b000, pipe_s4.hq}) : (base + {3'b000, pipe_s4.hq});
		if (hs >= HUE_SPAN) begin
			hs = hs - HUE_SPAN;
		end
		unique case (pipe_s4.piece)
			3'd0, 3'd6: begin rc = pipe_s4.c; gc = pipe_s4.x; bc = 8'd0;      end
			3'd1:       begin rc = pipe_s4.x; gc = pipe_s4.c; bc = 8'd0;      end
			3'd2:       begin rc = 8'd0;      gc = pipe_s4.c; bc = pipe_s4.x; end
			3'd3:       begin rc = 8'd0;      gc = pipe_s4.x; bc = pipe_s4.c; end
			3'd4:       begin rc = pipe_s4.x; gc = 8'd0;      bc = pipe_s4.c; end
			3'd5:       begin rc = pipe_s4.c; gc = 8'd0;      bc = pipe_s4.x; end
			default:    begin rc = 8'd0;      gc = 8'd0;      bc = 8'd0;      end
		endcase
		m = pipe_s4.v - pipe_s4.c;
		result_d = '0;
		if (pipe_s4.mode == MODE_HSV2RGB) begin
			result_d.red_out   = rc + m;
			result_d.green_out = gc + m;
			result_d.blue_out  = bc + m;
		end else begin
			// grey has no hue, black no saturation
			result_d.hue_out = (pipe_s4.c == 8'd0) ? 11'd0 : hs[10:0];
			if (pipe_s4.v == 8'd0) begin
				result_d.sat_out = 8'd0;
			end else if (pipe_s4.sq[8]) begin
				result_d.sat_out = 8'hFF;
			end else begin
				result_d.sat_out = pipe_s4.sq[7:0];
			end
			result_d.val_out = pipe_s4.v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s1  <= s1_d;
		pipe_s2  <= s2_d;
		pipe_s3  <= s3_d;
		pipe_s4  <= s4_d;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[hdl/rhc_checker.sv]
`timescale 1ns / 1ps
`include "rgb_hsv_color_converter_unit_assert.svh"
module rhc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input rhc_pkg::request_t request,
	input logic              done,
	input rhc_pkg::result_t  result
);
	import rhc_pkg::*;

	logic took_rgb, took_hsv;

	assign took_rgb = start && !busy && (request.mode == MODE_RGB2HSV);
	assign took_hsv = start && !busy && (request.mode == MODE_HSV2RGB);

	`RHC_ASSERT_NOW(a_never_busy, 1'b1, !busy, "converter raised busy")

	`RHC_ASSERT_NOW(a_no_stray_done, done, $past(start && !busy, LATENCY), "done without item")

	`RHC_ASSERT_NEXT(a_latency, start && !busy, ##(LATENCY - 1) done, "item result missing")

	`RHC_ASSERT_NOW(a_rgb_zero_in_hsv, done && $past(took_rgb, LATENCY), (result.red_out == 8'd0) && (result.green_out == 8'd0) && (result.blue_out == 8'd0) && (result.hue_out < HUE_CLAMP), "bad hsv result")

	`RHC_ASSERT_NOW(a_hsv_zero_in_rgb, done && $past(took_hsv, LATENCY), (result.hue_out == 11'd0) && (result.sat_out == 8'd0) && (result.val_out == 8'd0), "bad rgb result")

endmodule

bind rgb_hsv_color_converter_unit rhc_checker u_rhc_checker (.*);
